/* hdl/cdg_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the CD+G decoder.
package cdg_pkg;

  localparam int FRAME_WIDTH  = 300;
  localparam int FRAME_HEIGHT = 216;
  localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W       = $clog2(FRAME_PIXELS);

  localparam logic [1:0] MODE_APPLY = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_ACK   = 2'd3;

  localparam logic [5:0] CMD_GRAPHICS      = 6'd9;
  localparam logic [5:0] INS_MEM_PRESET    = 6'd1;
  localparam logic [5:0] INS_BORDER        = 6'd2;
  localparam logic [5:0] INS_TILE          = 6'd6;
  localparam logic [5:0] INS_TILE_XOR      = 6'd38;
  localparam logic [5:0] INS_SCROLL_PRESET = 6'd20;
  localparam logic [5:0] INS_SCROLL_COPY   = 6'd24;
  localparam logic [5:0] INS_PAL_LOW       = 6'd30;
  localparam logic [5:0] INS_PAL_HIGH      = 6'd31;

  // Decoded item kinds
  localparam logic [3:0] K_NONE   = 4'd0;
  localparam logic [3:0] K_READ   = 4'd1;
  localparam logic [3:0] K_CLEAR  = 4'd2;
  localparam logic [3:0] K_ACK    = 4'd3;
  localparam logic [3:0] K_FILL   = 4'd4;
  localparam logic [3:0] K_BORDER = 4'd5;
  localparam logic [3:0] K_TILE   = 4'd6;
  localparam logic [3:0] K_TILEX  = 4'd7;
  localparam logic [3:0] K_SCRP   = 4'd8;
  localparam logic [3:0] K_SCRC   = 4'd9;
  localparam logic [3:0] K_PAL    = 4'd10;

  // Pixel walker operations
  localparam logic [3:0] OP_ZERO   = 4'd0;
  localparam logic [3:0] OP_FILL   = 4'd1;
  localparam logic [3:0] OP_BORDER = 4'd2;
  localparam logic [3:0] OP_TILE   = 4'd3;
  localparam logic [3:0] OP_TILEX  = 4'd4;
  localparam logic [3:0] OP_SNAP   = 4'd5;
  localparam logic [3:0] OP_SCRP   = 4'd6;
  localparam logic [3:0] OP_SCRC   = 4'd7;
  localparam logic [3:0] OP_READ   = 4'd8;

  localparam logic [1:0] SRC_CONST = 2'd0;
  localparam logic [1:0] SRC_XOR   = 2'd1;
  localparam logic [1:0] SRC_SNAP  = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       start;
    logic [3:0] op;
    logic       pal_load;
    logic       pal_clear;
    logic       set_chg;
    logic       clr_chg;
    logic       out_load;
  } cdg_cmd_t;

  typedef struct packed {
    logic [3:0] kind;
    logic       done;
  } cdg_stat_t;

endpackage

/* hdl/cdg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cdg_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64800,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

/* hdl/cdg_ctrl.sv */
// Controller state machine: sequences boot clear, packet operations and result hand-off.
module cdg_ctrl import cdg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  cdg_stat_t stat,
  output cdg_cmd_t  cmd
);

  localparam logic [2:0] ST_BOOT   = 3'd0;
  localparam logic [2:0] ST_BOOTW  = 3'd1;
  localparam logic [2:0] ST_IDLE   = 3'd2;
  localparam logic [2:0] ST_DECODE = 3'd3;
  localparam logic [2:0] ST_RUN    = 3'd4;
  localparam logic [2:0] ST_SNAPW  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_BOOT: begin
        cmd.start = 1'b1;
        cmd.op    = OP_ZERO;
        state_nxt = ST_BOOTW;
      end
      ST_BOOTW: begin
        if (stat.done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_RUN;
        case (stat.kind)
          K_READ: begin
            cmd.start = 1'b1;
            cmd.op    = OP_READ;
          end
          K_CLEAR: begin
            cmd.pal_clear = 1'b1;
            cmd.set_chg   = 1'b1;
            cmd.start     = 1'b1;
            cmd.op        = OP_ZERO;
          end
          K_ACK: begin
            cmd.clr_chg = 1'b1;
            state_nxt   = ST_DONE;
          end
          K_FILL: begin
            cmd.set_chg = 1'b1;
            cmd.start   = 1'b1;
            cmd.op      = OP_FILL;
          end
          K_BORDER: begin
            cmd.set_chg = 1'b1;
            cmd.start   = 1'b1;
            cmd.op      = OP_BORDER;
          end
          K_TILE: begin
            cmd.set_chg = 1'b1;
            cmd.start   = 1'b1;
            cmd.op      = OP_TILE;
          end
          K_TILEX: begin
            cmd.set_chg = 1'b1;
            cmd.start   = 1'b1;
            cmd.op      = OP_TILEX;
          end
          K_SCRP, K_SCRC: begin
            cmd.start = 1'b1;
            cmd.op    = OP_SNAP;
            state_nxt = ST_SNAPW;
          end
          K_PAL: begin
            cmd.pal_load = 1'b1;
            cmd.set_chg  = 1'b1;
            state_nxt    = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_SNAPW: begin
        // snapshot taken: rewrite the frame from it
        if (stat.done) begin
          cmd.start   = 1'b1;
          cmd.set_chg = 1'b1;
          cmd.op      = (stat.kind == K_SCRP) ? OP_SCRP : OP_SCRC;
          state_nxt   = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_BOOT;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BOOT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/cdg_datapath.sv */
// Datapath: item latch, decode, pixel walker, frame and snapshot RAMs, palette, result.
module cdg_datapath import cdg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cdg_cmd_t    cmd,
  output cdg_stat_t   stat,
  input  logic [1:0]  mode,
  input  logic [5:0]  command,
  input  logic [5:0]  instruction,
  input  logic [47:0] data_lower,
  input  logic [47:0] data_upper,
  input  logic [8:0]  pixel_x,
  input  logic [7:0]  pixel_y,
  output logic [3:0]  color_index,
  output logic [23:0] pixel_rgb,
  output logic        frame_changed
);

  localparam logic [8:0] W_M1   = 9'(FRAME_WIDTH - 1);
  localparam logic [7:0] H_M1   = 8'(FRAME_HEIGHT - 1);
  localparam logic [8:0] W_LIM  = 9'(FRAME_WIDTH);
  localparam logic [7:0] H_LIM  = 8'(FRAME_HEIGHT);
  localparam logic [8:0] X_STEP = 9'd6;
  localparam logic [7:0] Y_STEP = 8'd12;
  localparam logic [8:0] X_FAR  = 9'(FRAME_WIDTH - 6);
  localparam logic [7:0] Y_FAR  = 8'(FRAME_HEIGHT - 12);

  function automatic logic [ADDR_W-1:0] pix_addr(input logic [8:0] x, input logic [7:0] y);
    logic [ADDR_W-1:0] yy;
    yy = ADDR_W'(y);
    // y * 300 = y*256 + y*32 + y*8 + y*4
    return (yy << 8) + (yy << 5) + (yy << 3) + (yy << 2) + ADDR_W'(x);
  endfunction

  logic [1:0]  mode_r;
  logic [5:0]  cmd_r, ins_r;
  logic [95:0] dat_r;
  logic [8:0]  px_r;
  logic [7:0]  py_r;
  logic [5:0]  byt [16];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= mode;
      cmd_r  <= command;
      ins_r  <= instruction;
      dat_r  <= {data_upper, data_lower};
      px_r   <= pixel_x;
      py_r   <= pixel_y;
    end
  end

  for (genvar k = 0; k < 16; k++) begin : g_byte
    assign byt[k] = dat_r[6*k +: 6];
  end

  logic [1:0] hc, vc;
  logic       hmove, vmove, tile_ok, in_range;
  logic [3:0] kind;

  assign hc       = byt[1][5:4];
  assign vc       = byt[2][5:4];
  assign hmove    = (hc == 2'd1) || (hc == 2'd2);
  assign vmove    = (vc == 2'd1) || (vc == 2'd2);
  assign tile_ok  = (byt[2][4:0] < 5'd18) && (byt[3] < 6'd50);
  assign in_range = (px_r < W_LIM) && (py_r < H_LIM);

  always_comb begin
    kind = K_NONE;
    case (mode_r)
      MODE_READ:  kind = in_range ? K_READ : K_NONE;
      MODE_CLEAR: kind = K_CLEAR;
      MODE_ACK:   kind = K_ACK;
      default: begin
        if (cmd_r == CMD_GRAPHICS) begin
          case (ins_r)
            INS_MEM_PRESET:    kind = (byt[1][3:0] == 4'd0) ? K_FILL : K_NONE;
            INS_BORDER:        kind = K_BORDER;
            INS_TILE:          kind = tile_ok ? K_TILE : K_NONE;
            INS_TILE_XOR:      kind = tile_ok ? K_TILEX : K_NONE;
            INS_SCROLL_PRESET: kind = (hmove || vmove) ? K_SCRP : K_NONE;
            INS_SCROLL_COPY:   kind = (hmove || vmove) ? K_SCRC : K_NONE;
            INS_PAL_LOW:       kind = K_PAL;
            INS_PAL_HIGH:      kind = K_PAL;
            default:           kind = K_NONE;
          endcase
        end
      end
    endcase
  end

  // Pixel walker, stage 0: raster scan over a rectangle
  logic       active_r;
  logic [3:0] op_r;
  logic [8:0] base_x_r, end_x_r, cx_r, x_abs, wx;
  logic [7:0] base_y_r, end_y_r, cy_r, y_abs, wy;
  logic       in_x, in_y, last0;
  logic [8:0] tile_x;
  logic [7:0] tile_y;

  assign tile_x = (9'(byt[3]) << 2) + (9'(byt[3]) << 1);
  assign tile_y = (8'(byt[2][4:0]) << 3) + (8'(byt[2][4:0]) << 2);
  assign last0  = (cx_r == end_x_r) && (cy_r == end_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (cmd.start) begin
      active_r <= 1'b1;
    end else if (active_r && last0) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r <= cmd.op;
      cx_r <= '0;
      cy_r <= '0;
      case (cmd.op)
        OP_TILE, OP_TILEX: begin
          base_x_r <= tile_x;
          base_y_r <= tile_y;
          end_x_r  <= X_STEP - 9'd1;
          end_y_r  <= Y_STEP - 8'd1;
        end
        OP_READ: begin
          base_x_r <= px_r;
          base_y_r <= py_r;
          end_x_r  <= '0;
          end_y_r  <= '0;
        end
        default: begin
          base_x_r <= '0;
          base_y_r <= '0;
          end_x_r  <= W_M1;
          end_y_r  <= H_M1;
        end
      endcase
    end else if (active_r) begin
      if (cx_r == end_x_r) begin
        cx_r <= '0;
        cy_r <= cy_r + 8'd1;
      end else begin
        cx_r <= cx_r + 9'd1;
      end
    end
  end

  assign x_abs = base_x_r + cx_r;
  assign y_abs = base_y_r + cy_r;

  // Wrapped source of a whole-tile scroll
  always_comb begin
    case (hc)
      2'd1: begin
        in_x = (x_abs >= X_STEP);
        wx   = in_x ? (x_abs - X_STEP) : (x_abs + X_FAR);
      end
      2'd2: begin
        in_x = (x_abs < X_FAR);
        wx   = in_x ? (x_abs + X_STEP) : (x_abs - X_FAR);
      end
      default: begin
        in_x = 1'b1;
        wx   = x_abs;
      end
    endcase
    case (vc)
      2'd1: begin
        in_y = (y_abs >= Y_STEP);
        wy   = in_y ? (y_abs - Y_STEP) : (y_abs + Y_FAR);
      end
      2'd2: begin
        in_y = (y_abs < Y_FAR);
        wy   = in_y ? (y_abs + Y_STEP) : (y_abs - Y_FAR);
      end
      default: begin
        in_y = 1'b1;
        wy   = y_abs;
      end
    endcase
  end

  logic              s0_wf, s0_ws, s0_rd, tbit;
  logic [1:0]        s0_src;
  logic [3:0]        s0_col;
  logic [ADDR_W-1:0] own_addr, rd_addr;
  logic [5:0]        tbits;

  assign own_addr = pix_addr(x_abs, y_abs);
  assign tbits    = byt[4'(cy_r[3:0] + 4'd4)];
  assign tbit     = tbits[3'd5 - cx_r[2:0]];

  always_comb begin
    s0_wf   = 1'b0;
    s0_ws   = 1'b0;
    s0_rd   = 1'b0;
    s0_src  = SRC_CONST;
    s0_col  = byt[0][3:0];
    rd_addr = own_addr;
    case (op_r)
      OP_ZERO: begin
        s0_wf  = 1'b1;
        s0_col = 4'd0;
      end
      OP_FILL: s0_wf = 1'b1;
      OP_BORDER: begin
        s0_wf = (y_abs < Y_STEP) || (y_abs >= Y_FAR) || (x_abs < X_STEP) || (x_abs >= X_FAR);
      end
      OP_TILE: begin
        s0_wf  = 1'b1;
        s0_col = tbit ? byt[1][3:0] : byt[0][3:0];
      end
      OP_TILEX: begin
        s0_wf  = 1'b1;
        s0_src = SRC_XOR;
        s0_col = tbit ? byt[1][3:0] : byt[0][3:0];
      end
      OP_SNAP: s0_ws = 1'b1;
      OP_SCRP: begin
        s0_wf   = 1'b1;
        s0_src  = (in_x && in_y) ? SRC_SNAP : SRC_CONST;
        rd_addr = pix_addr(wx, wy);
      end
      OP_SCRC: begin
        s0_wf   = 1'b1;
        s0_src  = SRC_SNAP;
        rd_addr = pix_addr(wx, wy);
      end
      OP_READ: s0_rd = 1'b1;
      default: s0_wf = 1'b0;
    endcase
  end

  // Stage 1: RAM read data arrives, write back
  logic              p1_v_r, p1_last_r, p1_wf_r, p1_ws_r, p1_rd_r;
  logic [1:0]        p1_src_r;
  logic [3:0]        p1_col_r;
  logic [ADDR_W-1:0] p1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else begin
      p1_v_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_last_r <= last0;
    p1_wf_r   <= s0_wf;
    p1_ws_r   <= s0_ws;
    p1_rd_r   <= s0_rd;
    p1_src_r  <= s0_src;
    p1_col_r  <= s0_col;
    p1_addr_r <= own_addr;
  end

  logic [3:0] frame_rdata, snap_rdata, frame_wdata;

  always_comb begin
    case (p1_src_r)
      SRC_XOR:  frame_wdata = frame_rdata ^ p1_col_r;
      SRC_SNAP: frame_wdata = snap_rdata;
      default:  frame_wdata = p1_col_r;
    endcase
  end

  cdg_ram #(.WIDTH(4), .DEPTH(FRAME_PIXELS)) u_frame (
    .clk   (clk),
    .we    (p1_v_r && p1_wf_r),
    .waddr (p1_addr_r),
    .wdata (frame_wdata),
    .raddr (own_addr),
    .rdata (frame_rdata)
  );

  cdg_ram #(.WIDTH(4), .DEPTH(FRAME_PIXELS)) u_snap (
    .clk   (clk),
    .we    (p1_v_r && p1_ws_r),
    .waddr (p1_addr_r),
    .wdata (frame_rdata),
    .raddr (rd_addr),
    .rdata (snap_rdata)
  );

  assign stat.kind = kind;
  assign stat.done = p1_v_r && p1_last_r;

  // Palette and changed flag
  logic [11:0] pal_r [16];
  logic        chg_r;
  logic        pal_hi;

  assign pal_hi = (ins_r == INS_PAL_HIGH);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.pal_clear) begin
      for (int i = 0; i < 16; i++) begin
        pal_r[i] <= '0;
      end
    end else if (cmd.pal_load) begin
      for (int i = 0; i < 8; i++) begin
        pal_r[{pal_hi, 3'(i)}] <= {byt[2*i], byt[2*i+1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chg_r <= 1'b1;
    end else if (cmd.set_chg) begin
      chg_r <= 1'b1;
    end else if (cmd.clr_chg) begin
      chg_r <= 1'b0;
    end
  end

  // Result
  logic [3:0]  res_idx_r;
  logic [23:0] res_rgb_r;
  logic [11:0] pcol;

  assign pcol = pal_r[frame_rdata];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_idx_r <= '0;
      res_rgb_r <= '0;
    end else if (p1_v_r && p1_rd_r) begin
      res_idx_r <= frame_rdata;
      res_rgb_r <= {pcol[11:8], pcol[11:8], pcol[7:4], pcol[7:4], pcol[3:0], pcol[3:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      color_index   <= res_idx_r;
      pixel_rgb     <= res_rgb_r;
      frame_changed <= chg_r;
    end
  end

endmodule

/* hdl/cdg_graphics_packet_decoder.sv */
// Top level of the CD+G graphics packet decoder.
// Keeps a 300x216 frame of 4-bit colour indices and a 16-entry palette, applies
// one packet or command per input beat and returns one result beat for each.
// After reset the frame is cleared by a pass over every pixel, during which
// no beat is taken. Work per item is set by the pixel walker that visits one
// pixel a cycle over the frame RAM: a pixel read visits one pixel; an
// acknowledge, palette load or ignored packet starts no walk; a tile block
// visits 6x12 pixels; a memory preset, border preset or clear walks the frame
// once; a scroll walks it twice (to a snapshot RAM, then back from it).
module cdg_graphics_packet_decoder import cdg_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [5:0] command, [11:6] instruction, [59:12] data_lower, [107:60] data_upper,
  // [116:108] pixel_x, [124:117] pixel_y, [127:125] zero
  input  logic [127:0] in_tdata,
  // [1:0] mode
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [3:0] color_index, [27:4] pixel_rgb, [28] frame_changed, [31:29] zero
  output logic [31:0]  out_tdata
);

  cdg_cmd_t    cmd;
  cdg_stat_t   stat;
  logic [3:0]  color_index;
  logic [23:0] pixel_rgb;
  logic        frame_changed;

  cdg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cdg_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (in_tuser),
    .command       (in_tdata[5:0]),
    .instruction   (in_tdata[11:6]),
    .data_lower    (in_tdata[59:12]),
    .data_upper    (in_tdata[107:60]),
    .pixel_x       (in_tdata[116:108]),
    .pixel_y       (in_tdata[124:117]),
    .color_index   (color_index),
    .pixel_rgb     (pixel_rgb),
    .frame_changed (frame_changed)
  );

  assign out_tdata = {3'b000, frame_changed, pixel_rgb, color_index};

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |-> !in_tready)
    else $error("walker finished while input side was open");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !in_tready)
    else $error("input opened while walker started");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("result loaded but not presented");

endmodule
